FILE: rtl/cbpw_pkg.sv
// cbpw_pkg: shared widths, register indexes, address window, bar color table
// and the configuration / result structs for the color bar pattern writer.
// No dependencies.
`default_nettype none

package cbpw_pkg;

  localparam int COORD_W   = 12;
  localparam int OFFSET_W  = 24;
  localparam int ADDR_W    = 32;
  localparam int PIXEL_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BAR_COUNT = 8;
  localparam int BAR_IDX_W = 3;

  localparam int DEF_MAX_WIDTH  = 1920;
  localparam int DEF_MAX_HEIGHT = 1080;

  localparam logic [ADDR_W-1:0] BASE_LOW = 32'ha010_0000;
  localparam logic [ADDR_W-1:0] BASE_END = 32'ha800_0000;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_BARS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE   = 3'd4;

  // reset values
  localparam logic [COORD_W-1:0] RST_FRAME_WIDTH  = 12'd1280;
  localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT = 12'd720;
  localparam logic [COORD_W-1:0] RST_ROW_PITCH    = 12'd1280;
  localparam logic               RST_VERTICAL     = 1'b1;
  localparam logic [ADDR_W-1:0]  RST_BUFFER_BASE  = 32'ha2a9_9450;

  typedef struct packed {
    logic [COORD_W-1:0] frame_width;
    logic [COORD_W-1:0] frame_height;
    logic [COORD_W-1:0] row_pitch;
    logic               vertical_bars;
    logic [ADDR_W-1:0]  buffer_base;
  } cfg_t;

  typedef struct packed {
    logic               emit;     // a result goes out for this request
    logic               cfg_bad;  // restart with rejected configuration
    logic               draw;     // a pixel is drawn
    logic               row_end;
    logic               last;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] value;
  } pix_res_t;

  function automatic logic [PIXEL_W-1:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
    logic [PIXEL_W-1:0] c;
    case (idx)
      3'd0:    c = 16'hf800;
      3'd1:    c = 16'h07e0;
      3'd2:    c = 16'h001f;
      3'd3:    c = 16'hffff;
      3'd4:    c = 16'h7c00;
      3'd5:    c = 16'h83e0;
      3'd6:    c = 16'hf0f0;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/color_bar_pattern_writer.sv
// color_bar_pattern_writer: at most one 16-bit pixel write per request, raster order.
// Flow: an accepted request waits in the input register and is loaded into the
// result register once the output is free; one request per cycle sustained
// while out_stall is low, set by the single pass through the pixel unit.
// Reset (rst, synchronous): config to defaults, idle, position cleared.
// Depends on cbpw_pkg and cbpw_pixel.
`default_nettype none

module color_bar_pattern_writer #(
  parameter int MAX_WIDTH  = cbpw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbpw_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [cbpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbpw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               restart,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cbpw_pkg::ADDR_W-1:0]             pixel_address,
  output logic [cbpw_pkg::PIXEL_W-1:0]            pixel_value,
  output logic                                    last_pixel,
  output logic                                    status
);

  cbpw_pkg::cfg_t                  cfg;
  logic [cbpw_pkg::COORD_W-1:0]    column;
  logic [cbpw_pkg::COORD_W-1:0]    row;
  logic [cbpw_pkg::OFFSET_W-1:0]   row_offset;
  logic                            drawing;
  logic                            s1_valid;
  logic                            s1_restart;
  logic                            out_free;
  logic                            s1_adv;
  cbpw_pkg::pix_res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= cbpw_pkg::RST_FRAME_WIDTH;
      cfg.frame_height  <= cbpw_pkg::RST_FRAME_HEIGHT;
      cfg.row_pitch     <= cbpw_pkg::RST_ROW_PITCH;
      cfg.vertical_bars <= cbpw_pkg::RST_VERTICAL;
      cfg.buffer_base   <= cbpw_pkg::RST_BUFFER_BASE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbpw_pkg::CFG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[cbpw_pkg::COORD_W-1:0];
        cbpw_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[cbpw_pkg::COORD_W-1:0];
        cbpw_pkg::CFG_ROW_PITCH:     cfg.row_pitch     <= cfg_data[cbpw_pkg::COORD_W-1:0];
        cbpw_pkg::CFG_VERTICAL_BARS: cfg.vertical_bars <= cfg_data[0];
        cbpw_pkg::CFG_BUFFER_BASE:   cfg.buffer_base   <= cfg_data[cbpw_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) s1_restart <= restart;
  end

  cbpw_pixel #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pixel (
    .cfg        (cfg),
    .column     (column),
    .row        (row),
    .row_offset (row_offset),
    .drawing    (drawing),
    .restart    (s1_restart),
    .res        (res)
  );

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      row_offset <= '0;
      drawing    <= 1'b0;
    end else if (s1_adv) begin
      if (res.cfg_bad || (res.draw && res.last)) begin
        column     <= '0;
        row        <= '0;
        row_offset <= '0;
        drawing    <= 1'b0;
      end else if (res.draw) begin
        drawing <= 1'b1;
        if (res.row_end) begin
          column     <= '0;
          row        <= (s1_restart ? '0 : row) + 1'b1;
          row_offset <= (s1_restart ? '0 : row_offset) + cbpw_pkg::OFFSET_W'(cfg.row_pitch);
        end else begin
          column <= (s1_restart ? '0 : column) + 1'b1;
          if (s1_restart) begin
            row        <= '0;
            row_offset <= '0;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && res.emit;
    end
    if (s1_adv && res.emit) begin
      pixel_address <= res.cfg_bad ? '0 : res.addr;
      pixel_value   <= res.cfg_bad ? '0 : res.value;
      last_pixel    <= !res.cfg_bad && res.last;
      status        <= res.cfg_bad;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cbpw_pixel.sv
// cbpw_pixel: combinational pixel unit - config check, bar index, address,
// row end and frame end for one request.
// Depends on cbpw_pkg.
`default_nettype none

module cbpw_pixel #(
  parameter int MAX_WIDTH  = cbpw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbpw_pkg::DEF_MAX_HEIGHT
) (
  input  var cbpw_pkg::cfg_t                    cfg,
  input  wire logic [cbpw_pkg::COORD_W-1:0]     column,
  input  wire logic [cbpw_pkg::COORD_W-1:0]     row,
  input  wire logic [cbpw_pkg::OFFSET_W-1:0]    row_offset,
  input  wire logic                             drawing,
  input  wire logic                             restart,
  output cbpw_pkg::pix_res_t                    res
);

  localparam logic [cbpw_pkg::COORD_W-1:0] MAX_W = cbpw_pkg::COORD_W'(MAX_WIDTH);
  localparam logic [cbpw_pkg::COORD_W-1:0] MAX_H = cbpw_pkg::COORD_W'(MAX_HEIGHT);
  localparam int PROD_W = cbpw_pkg::COORD_W + cbpw_pkg::BAR_IDX_W;

  // floor(8*pos/extent) by compares against constant multiples; zero extent -> 7
  function automatic logic [cbpw_pkg::BAR_IDX_W-1:0] bar_index(
    input logic [cbpw_pkg::COORD_W-1:0] pos,
    input logic [cbpw_pkg::COORD_W-1:0] extent
  );
    logic [PROD_W-1:0]              pos8;
    logic [PROD_W-1:0]              thr;
    logic [cbpw_pkg::BAR_IDX_W-1:0] idx;
    pos8 = {pos, {cbpw_pkg::BAR_IDX_W{1'b0}}};
    idx  = '0;
    for (int k = 1; k < cbpw_pkg::BAR_COUNT; k++) begin
      thr = PROD_W'(k) * PROD_W'(extent);
      if (pos8 >= thr) idx = cbpw_pkg::BAR_IDX_W'(k);
    end
    return idx;
  endfunction

  logic                             cfg_ok;
  logic                             eff_draw;
  logic [cbpw_pkg::COORD_W-1:0]     col_e;
  logic [cbpw_pkg::COORD_W-1:0]     row_e;
  logic [cbpw_pkg::OFFSET_W-1:0]    off_e;
  logic [cbpw_pkg::BAR_IDX_W-1:0]   idx;
  logic [cbpw_pkg::OFFSET_W:0]      lin;
  logic [cbpw_pkg::COORD_W:0]       col_inc;
  logic [cbpw_pkg::COORD_W:0]       row_inc;

  always_comb begin
    cfg_ok = (cfg.frame_width != '0) && (cfg.frame_width <= MAX_W) &&
             (cfg.frame_height != '0) && (cfg.frame_height <= MAX_H) &&
             (cfg.row_pitch >= cfg.frame_width) &&
             (cfg.buffer_base >= cbpw_pkg::BASE_LOW) &&
             (cfg.buffer_base < cbpw_pkg::BASE_END);

    col_e    = restart ? '0 : column;
    row_e    = restart ? '0 : row;
    off_e    = restart ? '0 : row_offset;
    eff_draw = restart ? cfg_ok : drawing;

    idx = cfg.vertical_bars ? bar_index(col_e, cfg.frame_width)
                            : bar_index(row_e, cfg.frame_height);

    lin     = {1'b0, off_e} + (cbpw_pkg::OFFSET_W + 1)'(col_e);
    col_inc = {1'b0, col_e} + 1'b1;
    row_inc = {1'b0, row_e} + 1'b1;

    res.cfg_bad = restart && !cfg_ok;
    res.draw    = eff_draw;
    res.emit    = eff_draw || res.cfg_bad;
    res.row_end = col_inc >= {1'b0, cfg.frame_width};
    res.last    = res.row_end && (row_inc >= {1'b0, cfg.frame_height});
    res.addr    = cfg.buffer_base + cbpw_pkg::ADDR_W'({lin, 1'b0});
    res.value   = cbpw_pkg::bar_color(idx);
  end

endmodule

`default_nettype wire
